[design/camr_pkg.sv]
// ----------------------------------------------------------------------------
// camr_pkg
// Types and constants for the addressing-mode resolver: mode codes and the
// request and response payloads.
// ----------------------------------------------------------------------------
package camr_pkg;

	localparam int unsigned ADDR_W = 24;
	localparam logic [15:0] MASK_LO = 16'h00ff;
	localparam logic [15:0] MASK_HI = 16'hff00;

	typedef enum logic [4:0] {
		MODE_IMPLIED      = 5'd0,
		MODE_ACCUMULATOR  = 5'd1,
		MODE_IMM_M        = 5'd2,
		MODE_IMM_X        = 5'd3,
		MODE_IMM_8        = 5'd4,
		MODE_DP           = 5'd5,
		MODE_DP_X         = 5'd6,
		MODE_DP_Y         = 5'd7,
		MODE_DP_IND       = 5'd8,
		MODE_DP_X_IND     = 5'd9,
		MODE_DP_IND_Y     = 5'd10,
		MODE_DP_LONG      = 5'd11,
		MODE_DP_LONG_Y    = 5'd12,
		MODE_ABS          = 5'd13,
		MODE_ABS_X        = 5'd14,
		MODE_ABS_Y        = 5'd15,
		MODE_ABS_IND      = 5'd16,
		MODE_ABS_LONG_IND = 5'd17,
		MODE_ABS_X_IND    = 5'd18,
		MODE_LONG         = 5'd19,
		MODE_LONG_X       = 5'd20,
		MODE_REL8         = 5'd21,
		MODE_REL16        = 5'd22,
		MODE_SR_S         = 5'd23,
		MODE_SR_S_IND_Y   = 5'd24,
		MODE_BLOCK_MOVE   = 5'd25
	} mode_t;

	typedef struct packed {
		logic [4:0]        mode;
		logic [ADDR_W-1:0] operand_bytes;
		logic [ADDR_W-1:0] pointer_data;
		logic [15:0]       direct_page;
		logic [7:0]        data_bank;
		logic [7:0]        program_bank;
		logic [15:0]       stack_pointer;
		logic [15:0]       index_x;
		logic [15:0]       index_y;
		logic              emulation_flag;
		logic              wide_accumulator;
		logic              wide_index;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] effective_address;
		logic              has_address;
		logic              is_immediate;
		logic              is_accumulator;
		logic [15:0]       operand_value;
		logic [7:0]        extra_byte;
		logic [1:0]        operand_size;
		logic [ADDR_W-1:0] pointer_low_address;
		logic [ADDR_W-1:0] pointer_high_address;
		logic [ADDR_W-1:0] pointer_bank_address;
		logic [1:0]        pointer_length;
		logic [1:0]        penalty_cycles;
	} rsp_t;

endpackage

[design/camr_calc.sv]
// ----------------------------------------------------------------------------
// camr_calc
// Address arithmetic for one request: pointer addresses, effective address,
// immediate and relative values, operand size and penalty cycles.
// ----------------------------------------------------------------------------
module camr_calc (
	input  camr_pkg::req_t req,
	output camr_pkg::rsp_t rsp
);
	import camr_pkg::*;

	logic [7:0]  op8;
	logic [15:0] op16;
	logic        dl_nz;
	logic        ewrap;
	logic [15:0] p16;
	logic [1:0]  accsz;
	logic [1:0]  idxsz;
	logic [15:0] idx;
	logic [15:0] dp_ptr;
	logic [15:0] dpi_ptr;
	logic [15:0] dpi_inc;
	logic [15:0] dpi_pgw;
	logic [15:0] dp_inc;
	logic [15:0] dp_pgw;
	logic [15:0] sr_ptr;
	logic [15:0] ax_ptr;
	logic [15:0] ix_sum;
	logic        page_cross;
	logic [15:0] cross_base;
	logic [23:0] ix_ea;
	logic [23:0] ix_base;
	logic [1:0]  dl_pen;

	assign op8   = req.operand_bytes[7:0];
	assign op16  = req.operand_bytes[15:0];
	assign dl_nz = |req.direct_page[7:0];
	assign ewrap = req.emulation_flag & ~dl_nz;
	assign p16   = req.pointer_data[15:0];
	assign accsz = req.wide_accumulator ? 2'd2 : 2'd1;
	assign idxsz = req.wide_index ? 2'd2 : 2'd1;
	assign dl_pen = {1'b0, dl_nz};

	// index source: Y for dp,Y and the Y-indexed modes, else X
	assign idx = (req.mode == MODE_DP_Y || req.mode == MODE_DP_IND_Y ||
		req.mode == MODE_ABS_Y || req.mode == MODE_DP_LONG_Y ||
		req.mode == MODE_SR_S_IND_Y) ? req.index_y : req.index_x;

	// plain direct-page pointer
	assign dp_ptr = req.direct_page + {8'h00, op8};
	assign dp_inc = dp_ptr + 16'd1;
	assign dp_pgw = (dp_ptr & MASK_HI) | (dp_inc & MASK_LO);

	// indexed direct-page pointer, page wrap in emulation with DL zero
	always_comb begin
		if (ewrap) begin
			dpi_ptr = (req.direct_page & MASK_HI) | (({8'h00, op8} + idx) & MASK_LO);
		end else begin
			dpi_ptr = req.direct_page + {8'h00, op8} + idx;
		end
	end
	assign dpi_inc = dpi_ptr + 16'd1;
	assign dpi_pgw = (dpi_ptr & MASK_HI) | (dpi_inc & MASK_LO);

	assign sr_ptr = req.stack_pointer + {8'h00, op8};
	assign ax_ptr = op16 + req.index_x;

	// shared indexed base for page-cross and bank carry
	always_comb begin
		unique case (req.mode)
			MODE_DP_IND_Y:   ix_base = {req.data_bank, p16};
			MODE_SR_S_IND_Y: ix_base = {req.data_bank, p16};
			MODE_DP_LONG_Y:  ix_base = req.pointer_data;
			MODE_LONG_X:     ix_base = req.operand_bytes;
			default:         ix_base = {req.data_bank, op16};
		endcase
	end
	assign cross_base = ix_base[15:0];
	assign ix_sum = cross_base + idx;
	assign ix_ea  = ix_base + {8'h00, idx};
	assign page_cross = (cross_base[15:8] != ix_sum[15:8]) || (idxsz == 2'd2);

	always_comb begin
		rsp = '0;
		unique case (req.mode)
			MODE_ACCUMULATOR: begin
				rsp.is_accumulator = 1'b1;
			end
			MODE_IMM_M, MODE_IMM_X, MODE_IMM_8: begin
				rsp.is_immediate = 1'b1;
				if (req.mode == MODE_IMM_M) begin
					rsp.operand_size = accsz;
				end else if (req.mode == MODE_IMM_X) begin
					rsp.operand_size = idxsz;
				end else begin
					rsp.operand_size = 2'd1;
				end
				rsp.operand_value = (rsp.operand_size == 2'd1) ? {8'h00, op8} : op16;
			end
			MODE_DP: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.penalty_cycles    = dl_pen;
				rsp.effective_address = {8'h00, dp_ptr};
			end
			MODE_DP_X, MODE_DP_Y: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.penalty_cycles    = dl_pen;
				rsp.effective_address = {8'h00, dpi_ptr};
			end
			MODE_DP_X_IND: begin
				rsp.has_address          = 1'b1;
				rsp.operand_size         = accsz;
				rsp.penalty_cycles       = dl_pen;
				rsp.pointer_low_address  = {8'h00, dpi_ptr};
				// emulation keeps the in-page high-byte read even with DL nonzero
				rsp.pointer_high_address = {8'h00,
					req.emulation_flag ? dpi_pgw : dpi_inc};
				rsp.pointer_length       = 2'd2;
				rsp.effective_address    = {req.data_bank, p16};
			end
			MODE_DP_IND, MODE_DP_IND_Y: begin
				rsp.has_address          = 1'b1;
				rsp.operand_size         = accsz;
				rsp.pointer_low_address  = {8'h00, dp_ptr};
				rsp.pointer_high_address = {8'h00, ewrap ? dp_pgw : dp_inc};
				rsp.pointer_length       = 2'd2;
				if (req.mode == MODE_DP_IND) begin
					rsp.penalty_cycles    = dl_pen;
					rsp.effective_address = {req.data_bank, p16};
				end else begin
					rsp.penalty_cycles    = dl_pen + {1'b0, page_cross};
					rsp.effective_address = ix_ea;
				end
			end
			MODE_DP_LONG, MODE_DP_LONG_Y: begin
				rsp.has_address          = 1'b1;
				rsp.operand_size         = accsz;
				rsp.penalty_cycles       = dl_pen;
				rsp.pointer_low_address  = {8'h00, dp_ptr};
				rsp.pointer_high_address = {8'h00, dp_inc};
				rsp.pointer_bank_address = {8'h00, dp_ptr + 16'd2};
				rsp.pointer_length       = 2'd3;
				rsp.effective_address    = (req.mode == MODE_DP_LONG) ?
					req.pointer_data : ix_ea;
			end
			MODE_ABS: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.effective_address = {req.data_bank, op16};
			end
			MODE_ABS_X, MODE_ABS_Y: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.penalty_cycles    = {1'b0, page_cross};
				rsp.effective_address = ix_ea;
			end
			MODE_ABS_IND: begin
				rsp.has_address          = 1'b1;
				rsp.pointer_low_address  = {8'h00, op16};
				rsp.pointer_high_address = {8'h00, op16 + 16'd1};
				rsp.pointer_length       = 2'd2;
				rsp.effective_address    = {8'h00, p16};
			end
			MODE_ABS_LONG_IND: begin
				rsp.has_address          = 1'b1;
				rsp.pointer_low_address  = {8'h00, op16};
				rsp.pointer_high_address = {8'h00, op16 + 16'd1};
				rsp.pointer_bank_address = {8'h00, op16 + 16'd2};
				rsp.pointer_length       = 2'd3;
				rsp.effective_address    = req.pointer_data;
			end
			MODE_ABS_X_IND: begin
				rsp.has_address          = 1'b1;
				rsp.pointer_low_address  = {req.program_bank, ax_ptr};
				rsp.pointer_high_address = {req.program_bank, ax_ptr + 16'd1};
				rsp.pointer_length       = 2'd2;
				rsp.effective_address    = {8'h00, p16};
			end
			MODE_LONG: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.effective_address = req.operand_bytes;
			end
			MODE_LONG_X: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.effective_address = ix_ea;
			end
			MODE_REL8: begin
				rsp.operand_value = {{8{op8[7]}}, op8};
			end
			MODE_REL16: begin
				rsp.operand_value = op16;
			end
			MODE_SR_S: begin
				rsp.has_address       = 1'b1;
				rsp.operand_size      = accsz;
				rsp.effective_address = {8'h00, sr_ptr};
			end
			MODE_SR_S_IND_Y: begin
				rsp.has_address          = 1'b1;
				rsp.operand_size         = accsz;
				rsp.pointer_low_address  = {8'h00, sr_ptr};
				rsp.pointer_high_address = {8'h00, sr_ptr + 16'd1};
				rsp.pointer_length       = 2'd2;
				rsp.effective_address    = ix_ea;
			end
			MODE_BLOCK_MOVE: begin
				rsp.operand_value = {8'h00, op8};
				rsp.extra_byte    = req.operand_bytes[15:8];
				rsp.operand_size  = 2'd2;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

[design/cpu_addressing_mode_resolver_unit.sv]
// ----------------------------------------------------------------------------
// cpu_addressing_mode_resolver_unit
// Effective-address unit for all 26 addressing modes of a 65816-style CPU.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled and returns one response per
// request, in order. A request is captured in an input register; the address
// arithmetic works on that register and its result lands in the response
// register once that register is free, so a response is offered after its
// request has passed through both registers. Throughput is one request per
// clock without stalls, limited only by the two-entry register pipeline;
// req_ready follows rsp_ready combinationally when both registers are full.
// Pointer bytes in the request must already have been read from the pointer
// addresses the response reports.
module cpu_addressing_mode_resolver_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  camr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output camr_pkg::rsp_t rsp
);
	import camr_pkg::*;

	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t calc_rsp;
	logic s2_free;
	logic load_s2;
	logic req_fire;

	assign s2_free   = ~valid_s2 | rsp_ready;
	assign load_s2   = valid_s1 & s2_free;
	assign req_ready = ~valid_s1 | s2_free;
	assign req_fire  = req_valid & req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (load_s2) begin
			rsp_s2 <= calc_rsp;
		end
	end

	camr_calc u_calc (
		.req (req_s1),
		.rsp (calc_rsp)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_no_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_address |-> rsp.effective_address == '0)
		else $error("effective address set without an address");

	a_ptr_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.pointer_length != 2'd1 && rsp.penalty_cycles != 2'd3)
		else $error("illegal pointer length or penalty");

	a_no_ptr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.pointer_length == 2'd0 |->
		rsp.pointer_low_address == '0 && rsp.pointer_high_address == '0 &&
		rsp.pointer_bank_address == '0)
		else $error("pointer address set without a pointer");

	a_imm_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_immediate |->
		!rsp.has_address && !rsp.is_accumulator && rsp.operand_size != 2'd0)
		else $error("immediate response carries an address or no size");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp_ready |-> !req_ready)
		else $error("request taken while pipeline is full and stalled");

endmodule

[sim/tb_cpu_addressing_mode_resolver_unit.sv]
// ----------------------------------------------------------------------------
// tb_cpu_addressing_mode_resolver_unit
// Drives addressing-mode requests into the resolver and checks every
// response against an in-bench address predictor or a fixed expected
// response. A short directed table covers each mode, the wrap rules and
// the field extremes. Random requests follow, with sender bursts,
// receiver stalls and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_cpu_addressing_mode_resolver_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import camr_pkg::*;

	localparam int RANDOM_REQUESTS = 1250;
	localparam int HOLD_OFF_START = 400;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

	typedef struct {
		req_t stim;
		bit   known;
		rsp_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	rsp_t          expected_addr_results[$];
	directed_row_t directed_rows[$];
	int            mismatch_count = 0;
	int            burst_left = 0;

	cpu_addressing_mode_resolver_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic rsp_t resolve_address(input req_t r);
		rsp_t        o;
		logic [7:0]  op8;
		logic [15:0] op16;
		logic [15:0] p16;
		logic [15:0] idx;
		logic [15:0] ptr;
		logic [15:0] nxt;
		logic [7:0]  lo8;
		logic [1:0]  acc_sz;
		logic [1:0]  idx_sz;
		logic        dl_nz;
		logic        ewrap;
		o = '0;
		op8 = r.operand_bytes[7:0];
		op16 = r.operand_bytes[15:0];
		p16 = r.pointer_data[15:0];
		dl_nz = r.direct_page[7:0] != 8'h00;
		ewrap = r.emulation_flag && !dl_nz;
		acc_sz = r.wide_accumulator ? 2'd2 : 2'd1;
		idx_sz = r.wide_index ? 2'd2 : 2'd1;
		idx = (r.mode == MODE_DP_Y) ? r.index_y : r.index_x;
		case (r.mode)
			MODE_ACCUMULATOR: o.is_accumulator = 1'b1;
			MODE_IMM_M, MODE_IMM_X, MODE_IMM_8: begin
				o.is_immediate = 1'b1;
				o.operand_size = (r.mode == MODE_IMM_M) ? acc_sz :
					(r.mode == MODE_IMM_X) ? idx_sz : 2'd1;
				o.operand_value = (o.operand_size == 2'd1) ? {8'h00, op8} : op16;
			end
			MODE_DP: begin
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				o.penalty_cycles = {1'b0, dl_nz};
				ptr = r.direct_page + {8'h00, op8};
				o.effective_address = {8'h00, ptr};
			end
			MODE_DP_X, MODE_DP_Y, MODE_DP_X_IND: begin
				o.penalty_cycles = {1'b0, dl_nz};
				lo8 = op8 + idx[7:0];
				if (ewrap)
					ptr = {r.direct_page[15:8], lo8};
				else
					ptr = r.direct_page + {8'h00, op8} + idx;
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				if (r.mode != MODE_DP_X_IND) begin
					o.effective_address = {8'h00, ptr};
				end else begin
					lo8 = ptr[7:0] + 8'h01;
					nxt = ptr + 16'h0001;
					o.pointer_low_address = {8'h00, ptr};
					o.pointer_high_address = r.emulation_flag ?
						{8'h00, ptr[15:8], lo8} : {8'h00, nxt};
					o.pointer_length = 2'd2;
					o.effective_address = {r.data_bank, p16};
				end
			end
			MODE_DP_IND, MODE_DP_IND_Y, MODE_DP_LONG, MODE_DP_LONG_Y: begin
				o.penalty_cycles = {1'b0, dl_nz};
				ptr = r.direct_page + {8'h00, op8};
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				o.pointer_low_address = {8'h00, ptr};
				if (r.mode == MODE_DP_IND || r.mode == MODE_DP_IND_Y) begin
					lo8 = ptr[7:0] + 8'h01;
					nxt = ptr + 16'h0001;
					o.pointer_high_address = ewrap ? {8'h00, ptr[15:8], lo8} : {8'h00, nxt};
					o.pointer_length = 2'd2;
					if (r.mode == MODE_DP_IND) begin
						o.effective_address = {r.data_bank, p16};
					end else begin
						nxt = p16 + r.index_y;
						if (p16[15:8] != nxt[15:8] || idx_sz == 2'd2)
							o.penalty_cycles = o.penalty_cycles + 2'd1;
						o.effective_address = {r.data_bank, p16} + {8'h00, r.index_y};
					end
				end else begin
					nxt = ptr + 16'h0001;
					o.pointer_high_address = {8'h00, nxt};
					nxt = ptr + 16'h0002;
					o.pointer_bank_address = {8'h00, nxt};
					o.pointer_length = 2'd3;
					o.effective_address = (r.mode == MODE_DP_LONG) ? r.pointer_data :
						r.pointer_data + {8'h00, r.index_y};
				end
			end
			MODE_ABS: begin
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				o.effective_address = {r.data_bank, op16};
			end
			MODE_ABS_X, MODE_ABS_Y: begin
				idx = (r.mode == MODE_ABS_Y) ? r.index_y : r.index_x;
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				nxt = op16 + idx;
				if (op16[15:8] != nxt[15:8] || idx_sz == 2'd2)
					o.penalty_cycles = 2'd1;
				o.effective_address = {r.data_bank, op16} + {8'h00, idx};
			end
			MODE_ABS_IND, MODE_ABS_LONG_IND: begin
				o.has_address = 1'b1;
				o.pointer_low_address = {8'h00, op16};
				nxt = op16 + 16'h0001;
				o.pointer_high_address = {8'h00, nxt};
				if (r.mode == MODE_ABS_IND) begin
					o.pointer_length = 2'd2;
					o.effective_address = {8'h00, p16};
				end else begin
					nxt = op16 + 16'h0002;
					o.pointer_bank_address = {8'h00, nxt};
					o.pointer_length = 2'd3;
					o.effective_address = r.pointer_data;
				end
			end
			MODE_ABS_X_IND: begin
				o.has_address = 1'b1;
				ptr = op16 + r.index_x;
				nxt = ptr + 16'h0001;
				o.pointer_low_address = {r.program_bank, ptr};
				o.pointer_high_address = {r.program_bank, nxt};
				o.pointer_length = 2'd2;
				o.effective_address = {8'h00, p16};
			end
			MODE_LONG: begin
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				o.effective_address = r.operand_bytes;
			end
			MODE_LONG_X: begin
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				o.effective_address = r.operand_bytes + {8'h00, r.index_x};
			end
			MODE_REL8: o.operand_value = {{8{op8[7]}}, op8};
			MODE_REL16: o.operand_value = op16;
			MODE_SR_S, MODE_SR_S_IND_Y: begin
				o.has_address = 1'b1;
				o.operand_size = acc_sz;
				ptr = r.stack_pointer + {8'h00, op8};
				if (r.mode == MODE_SR_S) begin
					o.effective_address = {8'h00, ptr};
				end else begin
					nxt = ptr + 16'h0001;
					o.pointer_low_address = {8'h00, ptr};
					o.pointer_high_address = {8'h00, nxt};
					o.pointer_length = 2'd2;
					o.effective_address = {r.data_bank, p16} + {8'h00, r.index_y};
				end
			end
			MODE_BLOCK_MOVE: begin
				o.operand_value = {8'h00, op8};
				o.extra_byte = r.operand_bytes[15:8];
				o.operand_size = 2'd2;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t make_req(input logic [4:0] mode, input logic [23:0] op,
		input logic [23:0] pd, input logic [15:0] d, input logic [7:0] db,
		input logic [7:0] pb, input logic [15:0] s, input logic [15:0] x,
		input logic [15:0] y, input logic emu, input logic wm, input logic wx);
		req_t r;
		r.mode = mode;
		r.operand_bytes = op;
		r.pointer_data = pd;
		r.direct_page = d;
		r.data_bank = db;
		r.program_bank = pb;
		r.stack_pointer = s;
		r.index_x = x;
		r.index_y = y;
		r.emulation_flag = emu;
		r.wide_accumulator = wm;
		r.wide_index = wx;
		return r;
	endfunction

	function automatic logic [15:0] pick16();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(0, 7))
			0: v = 16'h0000;
			1: v = 16'hffff;
			2: v[7:0] = 8'h00;
			3: v[7:0] = 8'hff;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [23:0] pick24();
		if ($urandom_range(0, 7) == 0)
			return 24'hffffff;
		return {8'($urandom), pick16()};
	endfunction

	task automatic add_row(input req_t stim, input bit known, input rsp_t want);
		directed_row_t row;
		row.stim = stim;
		row.known = known;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic send_request(input req_t stim, input rsp_t want);
		int gap;
		@(negedge clk);
		req <= stim;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		expected_addr_results.push_back(want);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_addr_results.size() == 0) begin
				$error("response with no request outstanding");
				mismatch_count++;
			end else begin
				want = expected_addr_results.pop_front();
				check_field("effective_address", want.effective_address, rsp.effective_address);
				check_field("has_address", want.has_address, rsp.has_address);
				check_field("is_immediate", want.is_immediate, rsp.is_immediate);
				check_field("is_accumulator", want.is_accumulator, rsp.is_accumulator);
				check_field("operand_value", want.operand_value, rsp.operand_value);
				check_field("extra_byte", want.extra_byte, rsp.extra_byte);
				check_field("operand_size", want.operand_size, rsp.operand_size);
				check_field("pointer_low_address", want.pointer_low_address,
					rsp.pointer_low_address);
				check_field("pointer_high_address", want.pointer_high_address,
					rsp.pointer_high_address);
				check_field("pointer_bank_address", want.pointer_bank_address,
					rsp.pointer_bank_address);
				check_field("pointer_length", want.pointer_length, rsp.pointer_length);
				check_field("penalty_cycles", want.penalty_cycles, rsp.penalty_cycles);
			end
		end
	end

	// receiver: random stalls at a rate re-picked from 0, 25, 50 or 90 percent, plus one long hold-off
	initial begin
		int cycle_count;
		int stall_pct;
		cycle_count = 0;
		stall_pct = 0;
		forever begin
			@(negedge clk);
			cycle_count++;
			if (cycle_count % 200 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 90;
				endcase
			end
			if (cycle_count >= HOLD_OFF_START && cycle_count < HOLD_OFF_START + HOLD_OFF_CYCLES)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		req_t stim;
		rsp_t want;
		rsp_t none;
		none = '0;

		add_row(make_req(MODE_IMPLIED, '1, '1, '1, '1, '1, '1, '1, '1, 1, 1, 1), 1, none);
		add_row(make_req(MODE_UNUSED_TOP, '1, '1, '1, '1, '1, '1, '1, '1, 1, 1, 1), 1, none);
		want = '0;
		want.is_accumulator = 1'b1;
		add_row(make_req(MODE_ACCUMULATOR, '1, '1, '1, '1, '1, '1, '1, '1, 1, 1, 1), 1, want);
		want = '0;
		want.is_immediate = 1'b1;
		want.operand_value = 16'hffff;
		want.operand_size = 2'd2;
		add_row(make_req(MODE_IMM_M, '1, '1, '1, '1, '1, '1, '1, '1, 1, 1, 1), 1, want);
		add_row(make_req(MODE_IMM_X, 24'h00abcd, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 0, none);
		add_row(make_req(MODE_IMM_8, 24'h0000ff, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1), 0, none);
		add_row(make_req(MODE_DP, 24'h0000ff, 0, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(make_req(MODE_DP_X, 24'h0000f0, 0, 16'h1200, 0, 0, 0, 16'h0020, 0, 1, 0, 0),
			0, none);
		add_row(make_req(MODE_DP_Y, 24'h0000ff, 0, 16'h0001, 0, 0, 0, 0, 16'hffff, 0, 1, 1),
			0, none);
		add_row(make_req(MODE_DP_X_IND, 24'h0000fe, 24'h123456, 16'h0101, 8'h7f, 0, 0, 0, 0,
			1, 0, 0), 0, none);
		add_row(make_req(MODE_DP_IND, 24'h0000ff, 24'h00beef, 16'h3400, 8'h01, 0, 0, 0, 0,
			1, 0, 0), 0, none);
		add_row(make_req(MODE_DP_IND_Y, 24'h000010, 24'h0012f0, 0, 8'hff, 0, 0, 0, 16'h0020,
			0, 1, 1), 0, none);
		add_row(make_req(MODE_DP_LONG, 0, 24'habcdef, 16'hffff, 0, 0, 0, 0, 0, 0, 1, 0),
			0, none);
		add_row(make_req(MODE_DP_LONG_Y, 0, 24'hffffff, 0, 0, 0, 0, 0, 16'h0001, 0, 0, 0),
			0, none);
		add_row(make_req(MODE_ABS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(make_req(MODE_ABS_X, 24'h00ffff, 0, 0, 8'hff, 0, 0, 16'hffff, 0, 0, 1, 1),
			0, none);
		add_row(make_req(MODE_ABS_Y, 24'h001234, 0, 0, 8'h12, 0, 0, 0, 16'h0010, 0, 0, 0),
			0, none);
		add_row(make_req(MODE_ABS_IND, 24'h00ffff, 24'h345678, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none);
		add_row(make_req(MODE_ABS_LONG_IND, 24'h00fffe, 24'h7e1234, 0, 0, 0, 0, 0, 0,
			0, 0, 0), 0, none);
		add_row(make_req(MODE_ABS_X_IND, 24'h00ffff, 24'h00c0de, 0, 0, 8'h7e, 0, 16'h0001, 0,
			0, 0, 0), 0, none);
		want = '0;
		want.has_address = 1'b1;
		want.effective_address = 24'hffffff;
		want.operand_size = 2'd2;
		add_row(make_req(MODE_LONG, '1, '1, '1, '1, '1, '1, '1, '1, 1, 1, 1), 1, want);
		add_row(make_req(MODE_LONG_X, 24'hffffff, 0, 0, 0, 0, 0, 16'h0001, 0, 0, 0, 0),
			0, none);
		want = '0;
		want.operand_value = 16'hff80;
		add_row(make_req(MODE_REL8, 24'h000080, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, want);
		want = '0;
		want.operand_value = 16'h8000;
		add_row(make_req(MODE_REL16, 24'hff8000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, want);
		add_row(make_req(MODE_SR_S, 24'h0000ff, 0, 0, 0, 0, 16'hffff, 0, 0, 0, 1, 0), 0, none);
		add_row(make_req(MODE_SR_S_IND_Y, 24'h000001, 24'h00ffff, 0, 8'h12, 0, 16'h01fe, 0,
			16'h0001, 0, 0, 0), 0, none);
		want = '0;
		want.operand_value = 16'h0056;
		want.extra_byte = 8'h34;
		want.operand_size = 2'd2;
		add_row(make_req(MODE_BLOCK_MOVE, 24'h123456, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, want);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].stim, directed_rows[i].known ?
				directed_rows[i].want : resolve_address(directed_rows[i].stim));

		repeat (RANDOM_REQUESTS) begin
			if ($urandom_range(0, 9) == 0)
				stim.mode = 5'($urandom_range(MODE_BLOCK_MOVE + 1, MODE_UNUSED_TOP));
			else
				stim.mode = 5'($urandom_range(MODE_IMPLIED, MODE_BLOCK_MOVE));
			stim.operand_bytes = pick24();
			stim.pointer_data = pick24();
			stim.direct_page = pick16();
			stim.data_bank = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
			stim.program_bank = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
			stim.stack_pointer = pick16();
			stim.index_x = pick16();
			stim.index_y = pick16();
			stim.emulation_flag = 1'($urandom);
			stim.wide_accumulator = 1'($urandom);
			stim.wide_index = 1'($urandom);
			send_request(stim, resolve_address(stim));
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_addr_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
